>>> rtl/pis_pkg.sv
//------------------------------------------------------------------------------
// pis_pkg
// Shared constants for the particle integrator step.
//------------------------------------------------------------------------------
package pis_pkg;

   localparam int COMPONENT_BITS_DEF = 21;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIME_STEP = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE      = 2'd1;

   localparam logic [15:0] TIME_STEP_RESET = 16'd655;
   localparam logic [16:0] DAMP_Q16        = 17'd64881;

   typedef enum logic [1:0] {
      MODE_EXPLICIT = 2'd0,
      MODE_SEMI     = 2'd1,
      MODE_VERLET   = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

endpackage

>>> rtl/particle_integrator_step.sv
//------------------------------------------------------------------------------
// particle_integrator_step
// One time step of a point particle: explicit Euler, semi-implicit Euler or
// damped position Verlet, with saturation of every component.
//------------------------------------------------------------------------------
// Fully pipelined: one word per clock. A word passes stages A to F, the
// bit-serial restoring divider for the Verlet velocity, one quotient bit per
// stage, and the output register. busy stays low; results appear on
// rsp_valid for one cycle and cannot be held off. Write the CSRs only while
// the pipeline is empty.
//------------------------------------------------------------------------------
module particle_integrator_step
   import pis_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [3*COMPONENT_BITS-1:0] req_position,
   input  logic [3*COMPONENT_BITS-1:0] req_previous_position,
   input  logic [3*COMPONENT_BITS-1:0] req_velocity,
   input  logic [3*COMPONENT_BITS-1:0] req_force_req,
   input  logic                      req_pinned,
   input  logic signed [15:0]        req_life_left,
   output logic                      rsp_valid,
   output logic [3*COMPONENT_BITS-1:0] rsp_new_position,
   output logic [3*COMPONENT_BITS-1:0] rsp_new_previous_position,
   output logic [3*COMPONENT_BITS-1:0] rsp_new_velocity,
   output logic                      rsp_was_updated,
   output logic                      rsp_saturated,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int CB = COMPONENT_BITS;
   localparam int VW = 3 * CB;
   localparam int QB = CB + 1;
   localparam int PW = CB + 17;
   localparam int DW = CB + 18;
   localparam int FW = CB + 33;
   localparam int AW = CB + 36;
   localparam int SW = CB + 8;
   localparam int MW = CB + 18;

   localparam logic signed [SW-1:0] SMAX = SW'((1 << (CB - 1)) - 1);
   localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
   localparam logic signed [PW-1:0] HALF16 = PW'(32768);
   localparam logic signed [AW-1:0] HALF32 = AW'(1) <<< 31;

   typedef logic signed [CB-1:0] comp_type;

   typedef struct packed {
      logic        vld;
      logic        go;
      logic [1:0]  mode;
      logic [15:0] dt;
   } ctl_type;

   typedef struct packed {
      logic [15:0]   rem;
      logic [QB-1:0] low;
      logic [QB-1:0] q;
      logic          ovf;
      logic          neg;
      comp_type      p;
      comp_type      q_in;
      comp_type      v;
      comp_type      p2;
      logic          pclip;
      comp_type      v2e;
      logic          vclip;
   } div_type;

   function automatic comp_type sat_c(input logic signed [SW-1:0] x);
      if (x > SMAX) return comp_type'(SMAX);
      if (x < SMIN) return comp_type'(SMIN);
      return comp_type'(x);
   endfunction

   function automatic logic clip_c(input logic signed [SW-1:0] x);
      return (x > SMAX) || (x < SMIN);
   endfunction

   // configuration
   logic [15:0] dt_ff;
   logic [1:0]  mode_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff   <= TIME_STEP_RESET;
         mode_ff <= MODE_EXPLICIT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TIME_STEP: dt_ff <= csr_data;
            CSR_MODE:      mode_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // stage A: capture
   ctl_type  a_ctl_ff, a_ctl_in;
   comp_type a_p_ff [3];
   comp_type a_q_ff [3];
   comp_type a_v_ff [3];
   comp_type a_f_ff [3];

   always_comb begin
      a_ctl_in.vld  = start && !busy;
      a_ctl_in.go   = !req_pinned && (req_life_left > 16'sd0) &&
                      (mode_ff != MODE_NONE);
      a_ctl_in.mode = mode_ff;
      a_ctl_in.dt   = dt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) a_ctl_ff.vld <= 1'b0;
      else       a_ctl_ff.vld <= a_ctl_in.vld;
      a_ctl_ff.go   <= a_ctl_in.go;
      a_ctl_ff.mode <= a_ctl_in.mode;
      a_ctl_ff.dt   <= a_ctl_in.dt;
      for (int i = 0; i < 3; i++) begin
         a_p_ff[i] <= req_position[i*CB +: CB];
         a_q_ff[i] <= req_previous_position[i*CB +: CB];
         a_v_ff[i] <= req_velocity[i*CB +: CB];
         a_f_ff[i] <= req_force_req[i*CB +: CB];
      end
   end

   // stage B: first products
   ctl_type  b_ctl_ff;
   comp_type b_p_ff [3];
   comp_type b_q_ff [3];
   comp_type b_v_ff [3];
   comp_type b_f_ff [3];
   logic signed [PW-1:0] b_fdt_ff [3];
   logic signed [PW-1:0] b_vdt_ff [3];
   logic signed [DW-1:0] b_pq_ff  [3];
   logic [31:0]          b_dtsq_ff;

   always_ff @(posedge clock) begin
      if (reset) b_ctl_ff.vld <= 1'b0;
      else       b_ctl_ff.vld <= a_ctl_ff.vld;
      b_ctl_ff.go   <= a_ctl_ff.go;
      b_ctl_ff.mode <= a_ctl_ff.mode;
      b_ctl_ff.dt   <= a_ctl_ff.dt;
      b_dtsq_ff     <= 32'(a_ctl_ff.dt) * 32'(a_ctl_ff.dt);
      for (int i = 0; i < 3; i++) begin
         b_p_ff[i]   <= a_p_ff[i];
         b_q_ff[i]   <= a_q_ff[i];
         b_v_ff[i]   <= a_v_ff[i];
         b_f_ff[i]   <= a_f_ff[i];
         b_fdt_ff[i] <= PW'(a_f_ff[i]) * $signed(PW'({1'b0, a_ctl_ff.dt}));
         b_vdt_ff[i] <= PW'(a_v_ff[i]) * $signed(PW'({1'b0, a_ctl_ff.dt}));
         b_pq_ff[i]  <= (DW'(a_p_ff[i]) - DW'(a_q_ff[i])) * $signed(DW'(DAMP_Q16));
      end
   end

   // stage C: Euler sums, f*dt*dt
   ctl_type  c_ctl_ff;
   comp_type c_p_ff [3];
   comp_type c_q_ff [3];
   comp_type c_v_ff [3];
   comp_type c_v2e_ff [3];
   logic     c_v2e_clip_ff [3];
   comp_type c_p2x_ff [3];
   logic     c_p2x_clip_ff [3];
   logic signed [DW-1:0] c_pq_ff [3];
   logic signed [FW-1:0] c_fdtdt_ff [3];

   always_ff @(posedge clock) begin
      logic signed [PW-1:0] rf, rv;
      logic signed [SW-1:0] sv, sp;
      if (reset) c_ctl_ff.vld <= 1'b0;
      else       c_ctl_ff.vld <= b_ctl_ff.vld;
      c_ctl_ff.go   <= b_ctl_ff.go;
      c_ctl_ff.mode <= b_ctl_ff.mode;
      c_ctl_ff.dt   <= b_ctl_ff.dt;
      for (int i = 0; i < 3; i++) begin
         rf = (b_fdt_ff[i] + HALF16) >>> 16;
         rv = (b_vdt_ff[i] + HALF16) >>> 16;
         sv = SW'(b_v_ff[i]) + SW'(rf);
         sp = SW'(b_p_ff[i]) + SW'(rv);
         c_p_ff[i]        <= b_p_ff[i];
         c_q_ff[i]        <= b_q_ff[i];
         c_v_ff[i]        <= b_v_ff[i];
         c_v2e_ff[i]      <= sat_c(sv);
         c_v2e_clip_ff[i] <= clip_c(sv);
         c_p2x_ff[i]      <= sat_c(sp);
         c_p2x_clip_ff[i] <= clip_c(sp);
         c_pq_ff[i]       <= b_pq_ff[i];
         c_fdtdt_ff[i]    <= FW'(b_f_ff[i]) * $signed(FW'({1'b0, b_dtsq_ff}));
      end
   end

   // stage D: v'*dt, Verlet accumulator
   ctl_type  d_ctl_ff;
   comp_type d_p_ff [3];
   comp_type d_q_ff [3];
   comp_type d_v_ff [3];
   comp_type d_v2e_ff [3];
   logic     d_v2e_clip_ff [3];
   comp_type d_p2x_ff [3];
   logic     d_p2x_clip_ff [3];
   logic signed [PW-1:0] d_v2dt_ff [3];
   logic signed [AW-1:0] d_acc_ff [3];

   always_ff @(posedge clock) begin
      if (reset) d_ctl_ff.vld <= 1'b0;
      else       d_ctl_ff.vld <= c_ctl_ff.vld;
      d_ctl_ff.go   <= c_ctl_ff.go;
      d_ctl_ff.mode <= c_ctl_ff.mode;
      d_ctl_ff.dt   <= c_ctl_ff.dt;
      for (int i = 0; i < 3; i++) begin
         d_p_ff[i]        <= c_p_ff[i];
         d_q_ff[i]        <= c_q_ff[i];
         d_v_ff[i]        <= c_v_ff[i];
         d_v2e_ff[i]      <= c_v2e_ff[i];
         d_v2e_clip_ff[i] <= c_v2e_clip_ff[i];
         d_p2x_ff[i]      <= c_p2x_ff[i];
         d_p2x_clip_ff[i] <= c_p2x_clip_ff[i];
         d_v2dt_ff[i]     <= PW'(c_v2e_ff[i]) * $signed(PW'({1'b0, c_ctl_ff.dt}));
         d_acc_ff[i]      <= (AW'(c_p_ff[i]) <<< 32) + (AW'(c_pq_ff[i]) <<< 16) +
                             AW'(c_fdtdt_ff[i]);
      end
   end

   // stage E: new position per mode
   ctl_type  e_ctl_ff;
   comp_type e_p_ff [3];
   comp_type e_q_ff [3];
   comp_type e_v_ff [3];
   comp_type e_v2e_ff [3];
   logic     e_vclip_ff [3];
   comp_type e_p2_ff [3];
   logic     e_pclip_ff [3];

   always_ff @(posedge clock) begin
      logic signed [PW-1:0] r1;
      logic signed [AW-1:0] r2;
      logic signed [SW-1:0] s1, s2;
      if (reset) e_ctl_ff.vld <= 1'b0;
      else       e_ctl_ff.vld <= d_ctl_ff.vld;
      e_ctl_ff.go   <= d_ctl_ff.go;
      e_ctl_ff.mode <= d_ctl_ff.mode;
      e_ctl_ff.dt   <= d_ctl_ff.dt;
      for (int i = 0; i < 3; i++) begin
         r1 = (d_v2dt_ff[i] + HALF16) >>> 16;
         r2 = (d_acc_ff[i] + HALF32) >>> 32;
         s1 = SW'(d_p_ff[i]) + SW'(r1);
         s2 = SW'(r2);
         e_p_ff[i]   <= d_p_ff[i];
         e_q_ff[i]   <= d_q_ff[i];
         e_v_ff[i]   <= d_v_ff[i];
         e_v2e_ff[i] <= d_v2e_ff[i];
         case (d_ctl_ff.mode)
            MODE_EXPLICIT: begin
               e_p2_ff[i]    <= d_p2x_ff[i];
               e_pclip_ff[i] <= d_p2x_clip_ff[i];
               e_vclip_ff[i] <= d_v2e_clip_ff[i];
            end
            MODE_SEMI: begin
               e_p2_ff[i]    <= sat_c(s1);
               e_pclip_ff[i] <= clip_c(s1);
               e_vclip_ff[i] <= d_v2e_clip_ff[i];
            end
            default: begin
               e_p2_ff[i]    <= sat_c(s2);
               e_pclip_ff[i] <= clip_c(s2);
               e_vclip_ff[i] <= 1'b0;
            end
         endcase
      end
   end

   // stage F (divider entry) and divider stages
   ctl_type dv_ctl_ff [QB+1];
   div_type dv_ff     [QB+1][3];

   always_ff @(posedge clock) begin
      logic signed [CB:0] d;
      logic [CB:0]        mag;
      logic [MW-1:0]      magp;
      if (reset) dv_ctl_ff[0].vld <= 1'b0;
      else       dv_ctl_ff[0].vld <= e_ctl_ff.vld;
      dv_ctl_ff[0].go   <= e_ctl_ff.go;
      dv_ctl_ff[0].mode <= e_ctl_ff.mode;
      dv_ctl_ff[0].dt   <= e_ctl_ff.dt;
      for (int i = 0; i < 3; i++) begin
         d    = (CB+1)'(e_p2_ff[i]) - (CB+1)'(e_p_ff[i]);
         mag  = d[CB] ? (CB+1)'(-d) : (CB+1)'(d);
         magp = MW'({mag, 16'h0000}) + MW'(e_ctl_ff.dt >> 1);
         dv_ff[0][i].rem   <= magp[QB +: 16];
         dv_ff[0][i].low   <= magp[QB-1:0];
         dv_ff[0][i].q     <= '0;
         dv_ff[0][i].ovf   <= magp >= MW'({e_ctl_ff.dt, {QB{1'b0}}});
         dv_ff[0][i].neg   <= d[CB];
         dv_ff[0][i].p     <= e_p_ff[i];
         dv_ff[0][i].q_in  <= e_q_ff[i];
         dv_ff[0][i].v     <= e_v_ff[i];
         dv_ff[0][i].p2    <= e_p2_ff[i];
         dv_ff[0][i].pclip <= e_pclip_ff[i];
         dv_ff[0][i].v2e   <= e_v2e_ff[i];
         dv_ff[0][i].vclip <= e_vclip_ff[i];
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_div
      always_ff @(posedge clock) begin
         logic [16:0] t;
         logic        ge;
         div_type     nx;
         if (reset) dv_ctl_ff[k+1].vld <= 1'b0;
         else       dv_ctl_ff[k+1].vld <= dv_ctl_ff[k].vld;
         dv_ctl_ff[k+1].go   <= dv_ctl_ff[k].go;
         dv_ctl_ff[k+1].mode <= dv_ctl_ff[k].mode;
         dv_ctl_ff[k+1].dt   <= dv_ctl_ff[k].dt;
         for (int i = 0; i < 3; i++) begin
            t  = {dv_ff[k][i].rem, dv_ff[k][i].low[QB-1-k]};
            ge = t >= {1'b0, dv_ctl_ff[k].dt};
            nx     = dv_ff[k][i];
            nx.rem = ge ? 16'(t - {1'b0, dv_ctl_ff[k].dt}) : t[15:0];
            nx.q   = QB'({dv_ff[k][i].q, ge});
            dv_ff[k+1][i] <= nx;
         end
      end
   end

   // output register
   logic          out_vld_ff;
   logic [VW-1:0] out_pos_ff, out_prev_ff, out_vel_ff;
   logic          out_upd_ff, out_sat_ff;

   always_ff @(posedge clock) begin
      logic [QB-1:0]        qv;
      logic signed [SW-1:0] vv;
      logic                 dtz, clip, vc;
      comp_type             v2;
      ctl_type              c;
      c    = dv_ctl_ff[QB];
      dtz  = c.dt == 16'h0000;
      clip = 1'b0;
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= c.vld;
      for (int i = 0; i < 3; i++) begin
         qv = dv_ff[QB][i].ovf ? {QB{1'b1}} : dv_ff[QB][i].q;
         vv = SW'($signed({1'b0, qv}));
         if (dv_ff[QB][i].neg) vv = -vv;
         if (c.mode == MODE_VERLET) begin
            v2 = dtz ? comp_type'(0) : sat_c(vv);
            vc = !dtz && clip_c(vv);
         end else begin
            v2 = dv_ff[QB][i].v2e;
            vc = dv_ff[QB][i].vclip;
         end
         clip = clip | vc | dv_ff[QB][i].pclip;
         out_pos_ff[i*CB +: CB]  <= c.go ? dv_ff[QB][i].p2 : dv_ff[QB][i].p;
         out_prev_ff[i*CB +: CB] <= c.go ? dv_ff[QB][i].p : dv_ff[QB][i].q_in;
         out_vel_ff[i*CB +: CB]  <= c.go ? v2 : dv_ff[QB][i].v;
      end
      out_upd_ff <= c.go;
      out_sat_ff <= c.go && clip;
   end

   assign rsp_valid                 = out_vld_ff;
   assign rsp_new_position          = out_pos_ff;
   assign rsp_new_previous_position = out_prev_ff;
   assign rsp_new_velocity          = out_vel_ff;
   assign rsp_was_updated           = out_upd_ff;
   assign rsp_saturated             = out_sat_ff;

endmodule
